@@ src/lfupr_pkg.sv @@
package lfupr_pkg;

    localparam int FRAMES  = 8;
    localparam int FRAME_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int PAGE_W  = 20;
    localparam int COUNT_W = 16;
    localparam int WORD_W  = 32;
    localparam int CFG_W   = 4;
    localparam int INDEX_W = 3;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(8);

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;     // take a new reference, start the scan
        logic scan;     // examine one frame
        logic commit;   // update the chosen frame and the result word
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic match;    // frame under the scan pointer holds the page
        logic last;     // scan pointer is at the last active frame
        logic out_free; // result register can take a new word
    } status_t;

    function automatic logic [WORD_W-1:0] sat_inc_word(input logic [WORD_W-1:0] v);
        return (v == '1) ? v : v + WORD_W'(1);
    endfunction

    function automatic logic [COUNT_W-1:0] sat_inc_count(input logic [COUNT_W-1:0] v);
        return (v == '1) ? v : v + COUNT_W'(1);
    endfunction

endpackage

@@ src/lfupr_ctrl.sv @@
module lfupr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  lfupr_pkg::status_t status,
    output lfupr_pkg::cmd_t   cmd
);
    import lfupr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (status.match || status.last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ src/lfupr_datapath.sv @@
module lfupr_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  lfupr_pkg::cmd_t                cmd,
    output lfupr_pkg::status_t             status,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lfupr_pkg::CFG_W-1:0]    cfg_data,
    input  logic [lfupr_pkg::PAGE_W-1:0]   s_page_number,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_hit,
    output logic [lfupr_pkg::INDEX_W-1:0]  m_frame_index,
    output logic                           m_replaced,
    output logic [lfupr_pkg::PAGE_W-1:0]   m_evicted_page,
    output logic [lfupr_pkg::WORD_W-1:0]   m_fault_total,
    output logic [lfupr_pkg::WORD_W-1:0]   m_hit_total
);
    import lfupr_pkg::*;

    // frame table
    logic [PAGE_W-1:0]  page_reg  [FRAMES];
    logic [FRAMES-1:0]  valid_reg;
    logic [COUNT_W-1:0] count_reg [FRAMES];
    logic [WORD_W-1:0]  stamp_reg [FRAMES];

    logic [CFG_W-1:0]   active_reg;
    logic [WORD_W-1:0]  tick_reg, faults_reg, hits_reg;

    // per-reference working registers
    logic [PAGE_W-1:0]  ref_page_reg;
    logic [FRAME_W-1:0] last_idx_reg;
    logic [FRAME_W-1:0] idx_reg;
    logic               found_reg;
    logic [FRAME_W-1:0] hit_idx_reg;
    logic [COUNT_W-1:0] hit_count_reg;
    logic               empty_found_reg;
    logic [FRAME_W-1:0] empty_idx_reg;
    logic [FRAME_W-1:0] best_idx_reg;
    logic [COUNT_W-1:0] best_count_reg;
    logic [WORD_W-1:0]  best_stamp_reg;
    logic [PAGE_W-1:0]  best_page_reg;

    // result register
    logic               out_valid_reg;
    logic               out_hit_reg;
    logic [INDEX_W-1:0] out_index_reg;
    logic               out_repl_reg;
    logic [PAGE_W-1:0]  out_evicted_reg;
    logic [WORD_W-1:0]  out_faults_reg;
    logic [WORD_W-1:0]  out_hits_reg;

    logic [FRAME_W-1:0] last_idx_next;
    logic               rd_valid;
    logic [PAGE_W-1:0]  rd_page;
    logic [COUNT_W-1:0] rd_count;
    logic [WORD_W-1:0]  rd_stamp;
    logic               rd_match;
    logic               rd_better;
    logic [FRAME_W-1:0] fill_idx;
    logic [WORD_W-1:0]  faults_inc, hits_inc;

    // clamp the active frame count, kept as the last index to scan
    always_comb begin
        if (active_reg == '0) begin
            last_idx_next = '0;
        end else if (int'(active_reg) > FRAMES) begin
            last_idx_next = FRAME_W'(FRAMES - 1);
        end else begin
            last_idx_next = FRAME_W'(active_reg - CFG_W'(1));
        end
    end

    assign rd_valid  = valid_reg[idx_reg];
    assign rd_page   = page_reg[idx_reg];
    assign rd_count  = count_reg[idx_reg];
    assign rd_stamp  = stamp_reg[idx_reg];
    assign rd_match  = rd_valid && (rd_page == ref_page_reg);
    assign rd_better = (idx_reg == '0) || (rd_count < best_count_reg) ||
                       ((rd_count == best_count_reg) && (rd_stamp < best_stamp_reg));

    assign fill_idx   = empty_found_reg ? empty_idx_reg : best_idx_reg;
    assign faults_inc = sat_inc_word(faults_reg);
    assign hits_inc   = sat_inc_word(hits_reg);

    assign status.match    = rd_match;
    assign status.last     = (idx_reg == last_idx_reg);
    assign status.out_free = !out_valid_reg || m_ready;

    assign cfg_ready = 1'b1;

    // config, time, totals, result valid flag and the frame table's valid flags, use counts and stamps
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= ACTIVE_RESET;
            valid_reg     <= '0;
            tick_reg      <= '0;
            faults_reg    <= '0;
            hits_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < FRAMES; i++) begin
                count_reg[i] <= '0;
                stamp_reg[i] <= '0;
            end
        end else begin
            if (cfg_valid) begin
                active_reg <= cfg_data;
            end
            if (cmd.load) begin
                tick_reg <= sat_inc_word(tick_reg);
            end
            if (cmd.commit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.commit) begin
                if (found_reg) begin
                    hits_reg               <= hits_inc;
                    count_reg[hit_idx_reg] <= hit_count_reg;
                    stamp_reg[hit_idx_reg] <= tick_reg;
                end else begin
                    faults_reg          <= faults_inc;
                    valid_reg[fill_idx] <= 1'b1;
                    count_reg[fill_idx] <= COUNT_W'(1);
                    stamp_reg[fill_idx] <= tick_reg;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ref_page_reg    <= s_page_number;
            last_idx_reg    <= last_idx_next;
            idx_reg         <= '0;
            found_reg       <= 1'b0;
            empty_found_reg <= 1'b0;
        end
        if (cmd.scan) begin
            idx_reg <= idx_reg + FRAME_W'(1);
            if (rd_match) begin
                found_reg     <= 1'b1;
                hit_idx_reg   <= idx_reg;
                hit_count_reg <= sat_inc_count(rd_count);
            end
            if (!rd_valid && !empty_found_reg) begin
                empty_found_reg <= 1'b1;
                empty_idx_reg   <= idx_reg;
            end
            if (rd_better) begin
                best_idx_reg   <= idx_reg;
                best_count_reg <= rd_count;
                best_stamp_reg <= rd_stamp;
                best_page_reg  <= rd_page;
            end
        end
        if (cmd.commit) begin
            if (found_reg) begin
                out_hit_reg     <= 1'b1;
                out_index_reg   <= INDEX_W'(hit_idx_reg);
                out_repl_reg    <= 1'b0;
                out_evicted_reg <= '0;
                out_faults_reg  <= faults_reg;
                out_hits_reg    <= hits_inc;
            end else begin
                page_reg[fill_idx] <= ref_page_reg;
                out_hit_reg        <= 1'b0;
                out_index_reg      <= INDEX_W'(fill_idx);
                out_repl_reg       <= !empty_found_reg;
                out_evicted_reg    <= empty_found_reg ? '0 : best_page_reg;
                out_faults_reg     <= faults_inc;
                out_hits_reg       <= hits_reg;
            end
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_hit          = out_hit_reg;
    assign m_frame_index  = out_index_reg;
    assign m_replaced     = out_repl_reg;
    assign m_evicted_page = out_evicted_reg;
    assign m_fault_total  = out_faults_reg;
    assign m_hit_total    = out_hits_reg;

endmodule

@@ src/lfu_page_replacement.sv @@
// lfu page replacement with least-recently-used tie break
//
// input channel (s_valid / s_ready / s_page_number): one word is one page
// reference. result channel (m_valid / m_ready / m_*): one word per reference
// with hit flag, frame index, eviction info and the running fault and hit
// totals. config channel (cfg_valid / cfg_ready / cfg_data): sets the number
// of active frames; write it only while no reference is in flight.
//
// sequence: the reference is taken in the idle state, then the scan examines one
// active frame per cycle (it stops early on a hit), then the finish state writes
// the frame table and loads the result register once the output register is
// free. a new reference is taken only after the last one has been committed;
// the scan over the frame table through a single read pointer sets its length.
//
// reset (aresetn, synchronous, active low) empties every frame, clears use
// counts, stamps, time and totals, and sets eight active frames.
// a stalled receiver holds the result word in the output register; the next
// reference is still taken and scanned, and waits in its final cycle until
// the output register is free.
module lfu_page_replacement (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lfupr_pkg::CFG_W-1:0]    cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [lfupr_pkg::PAGE_W-1:0]   s_page_number,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_hit,
    output logic [lfupr_pkg::INDEX_W-1:0]  m_frame_index,
    output logic                           m_replaced,
    output logic [lfupr_pkg::PAGE_W-1:0]   m_evicted_page,
    output logic [lfupr_pkg::WORD_W-1:0]   m_fault_total,
    output logic [lfupr_pkg::WORD_W-1:0]   m_hit_total
);
    import lfupr_pkg::*;

    // command and status between sequencer and datapath
    cmd_t    cmd;
    status_t status;

    // sequencer: idle, scan, finish
    lfupr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // frame table, scan registers, totals and result register
    lfupr_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_page_number  (s_page_number),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hit          (m_hit),
        .m_frame_index  (m_frame_index),
        .m_replaced     (m_replaced),
        .m_evicted_page (m_evicted_page),
        .m_fault_total  (m_fault_total),
        .m_hit_total    (m_hit_total)
    );

endmodule

@@ tb/lfu_page_replacement_check.sv @@
`timescale 1ns / 100ps

module lfu_page_replacement_check (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [lfupr_pkg::CFG_W-1:0]     cfg_data,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic [lfupr_pkg::PAGE_W-1:0]    s_page_number,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic                            m_hit,
    input  logic [lfupr_pkg::INDEX_W-1:0]   m_frame_index,
    input  logic                            m_replaced,
    input  logic [lfupr_pkg::PAGE_W-1:0]    m_evicted_page,
    input  logic [lfupr_pkg::WORD_W-1:0]    m_fault_total,
    input  logic [lfupr_pkg::WORD_W-1:0]    m_hit_total,
    output int                              outstanding,
    output int                              fail_count
);
    import lfupr_pkg::*;

    localparam int PRINT_CAP = 100;

    typedef struct {
        logic                hit;
        logic [INDEX_W-1:0]  frame_index;
        logic                replaced;
        logic [PAGE_W-1:0]   evicted_page;
        logic [WORD_W-1:0]   fault_total;
        logic [WORD_W-1:0]   hit_total;
    } placement_t;

    logic [CFG_W-1:0]   active_setting;
    logic [PAGE_W-1:0]  page_at   [FRAMES];
    logic               occupied  [FRAMES];
    logic [COUNT_W-1:0] use_count [FRAMES];
    logic [WORD_W-1:0]  stamp     [FRAMES];
    logic [WORD_W-1:0]  now;
    logic [WORD_W-1:0]  fault_sum;
    logic [WORD_W-1:0]  hit_sum;

    placement_t placements_due[$];
    int         mismatches = 0;

    // one page reference against the frame table
    function automatic placement_t place_reference(input logic [PAGE_W-1:0] page);
        placement_t p;
        int         span;
        int         slot;
        bit         found;
        bit         vacant;
        span   = (active_setting == '0) ? 1 :
                 (int'(active_setting) > FRAMES) ? FRAMES : int'(active_setting);
        slot   = 0;
        found  = 0;
        vacant = 0;
        p.replaced     = 1'b0;
        p.evicted_page = '0;
        if (now != '1)
            now = now + WORD_W'(1);
        for (int j = 0; j < span && !found; j++) begin
            if (occupied[j] && page_at[j] == page) begin
                slot  = j;
                found = 1;
            end
        end
        if (found) begin
            if (hit_sum != '1)
                hit_sum = hit_sum + WORD_W'(1);
            if (use_count[slot] != '1)
                use_count[slot] = use_count[slot] + COUNT_W'(1);
            stamp[slot] = now;
        end else begin
            if (fault_sum != '1)
                fault_sum = fault_sum + WORD_W'(1);
            for (int j = 0; j < span && !vacant; j++) begin
                if (!occupied[j]) begin
                    slot   = j;
                    vacant = 1;
                end
            end
            if (!vacant) begin
                // fewest uses first, then oldest stamp, then lowest frame
                slot = 0;
                for (int j = 1; j < span; j++) begin
                    if (use_count[j] < use_count[slot] ||
                        (use_count[j] == use_count[slot] && stamp[j] < stamp[slot]))
                        slot = j;
                end
                p.replaced     = 1'b1;
                p.evicted_page = page_at[slot];
            end
            page_at[slot]   = page;
            occupied[slot]  = 1'b1;
            use_count[slot] = COUNT_W'(1);
            stamp[slot]     = now;
        end
        p.hit         = found;
        p.frame_index = slot[INDEX_W-1:0];
        p.fault_total = fault_sum;
        p.hit_total   = hit_sum;
        return p;
    endfunction

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        if (mismatches < PRINT_CAP)
            $display("%0t: %s got %h want %h", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        placement_t want;
        if (!aresetn) begin
            active_setting = ACTIVE_RESET;
            for (int f = 0; f < FRAMES; f++) begin
                page_at[f]   = '0;
                occupied[f]  = 1'b0;
                use_count[f] = '0;
                stamp[f]     = '0;
            end
            now       = '0;
            fault_sum = '0;
            hit_sum   = '0;
            placements_due.delete();
        end else begin
            // result side first: a word leaving now cannot belong to a page taken now
            if (m_valid && m_ready) begin
                if (placements_due.size() == 0) begin
                    report_mismatch("result word with nothing due, hit_total", m_hit_total, '0);
                end else begin
                    want = placements_due.pop_front();
                    if (m_hit !== want.hit)
                        report_mismatch("hit", WORD_W'(m_hit), WORD_W'(want.hit));
                    if (m_frame_index !== want.frame_index)
                        report_mismatch("frame_index", WORD_W'(m_frame_index),
                                        WORD_W'(want.frame_index));
                    if (m_replaced !== want.replaced)
                        report_mismatch("replaced", WORD_W'(m_replaced), WORD_W'(want.replaced));
                    if (m_evicted_page !== want.evicted_page)
                        report_mismatch("evicted_page", WORD_W'(m_evicted_page),
                                        WORD_W'(want.evicted_page));
                    if (m_fault_total !== want.fault_total)
                        report_mismatch("fault_total", m_fault_total, want.fault_total);
                    if (m_hit_total !== want.hit_total)
                        report_mismatch("hit_total", m_hit_total, want.hit_total);
                end
            end
            if (s_valid && s_ready)
                placements_due.push_back(place_reference(s_page_number));
            if (cfg_valid && cfg_ready)
                active_setting = cfg_data;
        end
        outstanding <= placements_due.size();
        fail_count  <= mismatches;
    end

endmodule

@@ tb/lfu_page_replacement_test.sv @@
`timescale 1ns / 100ps

module lfu_page_replacement_test;
    import lfupr_pkg::*;

    // cycles with no word moving on any channel before the run is abandoned
    localparam int STALL_LIMIT   = 5000;
    // quiet time after the last due result word, enough for a reference to scan all eight built frames
    localparam int SETTLE_CYCLES = 12;
    localparam int MIX_ITEMS     = 55;
    localparam int POOL_MAX      = 12;

    logic                aclk;
    logic                aresetn;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_data;
    logic                s_valid;
    logic                s_ready;
    logic [PAGE_W-1:0]   s_page_number;
    logic                m_valid;
    logic                m_ready;
    logic                m_hit;
    logic [INDEX_W-1:0]  m_frame_index;
    logic                m_replaced;
    logic [PAGE_W-1:0]   m_evicted_page;
    logic [WORD_W-1:0]   m_fault_total;
    logic [WORD_W-1:0]   m_hit_total;

    int outstanding;
    int fail_count;
    int send_gap = 0;       // percent of cycles the sender holds back
    int recv_gap = 0;       // percent of cycles the receiver stalls
    int quiet_cycles = 0;

    lfu_page_replacement dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_page_number  (s_page_number),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hit          (m_hit),
        .m_frame_index  (m_frame_index),
        .m_replaced     (m_replaced),
        .m_evicted_page (m_evicted_page),
        .m_fault_total  (m_fault_total),
        .m_hit_total    (m_hit_total)
    );

    lfu_page_replacement_check placement_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_page_number  (s_page_number),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hit          (m_hit),
        .m_frame_index  (m_frame_index),
        .m_replaced     (m_replaced),
        .m_evicted_page (m_evicted_page),
        .m_fault_total  (m_fault_total),
        .m_hit_total    (m_hit_total),
        .outstanding    (outstanding),
        .fail_count     (fail_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // receiver: stalls at random, rate set per phase
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            m_ready <= ($urandom_range(99) >= recv_gap);
        end
    end

    // watchdog: any accepted word on any channel restarts the count
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // one page reference; valid stays up with the page fixed until taken
    task automatic send_page(input logic [PAGE_W-1:0] page);
        while ($urandom_range(99) < send_gap) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_page_number <= page;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // stop sending and let every due result word drain, then let the block go quiet
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // frame count only changes while the block is idle
    task automatic write_active(input logic [CFG_W-1:0] frames);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= frames;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // mostly a small working set so hits and evictions both happen,
    // with stray random pages mixed in
    task automatic run_mix(input int count);
        logic [PAGE_W-1:0] pool [POOL_MAX];
        int                pool_size;
        pool_size = $urandom_range(POOL_MAX, 1);
        foreach (pool[i])
            pool[i] = PAGE_W'($urandom);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(99) < 85)
                send_page(pool[$urandom_range(pool_size - 1)]);
            else
                send_page(PAGE_W'($urandom));
        end
    endtask

    initial begin
        logic [CFG_W-1:0]  plan [9];

        aresetn       <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        s_valid       <= 1'b0;
        s_page_number <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // frame counts per random stretch: the extremes, out-of-range values, random
        plan = '{CFG_W'(1), CFG_W'(15), CFG_W'(0), CFG_W'(8), CFG_W'(0), CFG_W'(0),
                 CFG_W'(0), CFG_W'(0), CFG_W'(5)};
        for (int i = 4; i < 8; i++)
            plan[i] = CFG_W'($urandom_range(15));

        send_gap = 8;
        recv_gap = 87;

        // directed, eight frames from reset: fill the empty frames, first with extreme pages
        send_page(20'h00000);
        send_page(20'hFFFFF);
        for (int p = 1; p <= 6; p++)
            send_page(PAGE_W'(p));
        // hits raise use counts and carry no eviction
        send_page(20'hFFFFF);
        send_page(20'hFFFFF);
        send_page(20'h00001);
        // table full: evictions by fewest uses, then oldest stamp
        send_page(20'h55555);
        send_page(20'hAAAAA);
        send_page(20'h00000);

        // single frame: every new page evicts the one before
        write_active(CFG_W'(1));
        send_page(20'h00007);
        send_page(20'h00007);
        send_page(20'h00008);
        // zero behaves as one frame
        write_active(CFG_W'(0));
        send_page(20'h00009);
        send_page(20'h00009);
        // above the built count behaves as all frames; parked frames kept their pages
        write_active(CFG_W'(15));
        send_page(20'hFFFFF);
        // pages parked beyond the active count are not found
        write_active(CFG_W'(4));
        send_page(20'h00005);
        send_page(20'h00006);

        // random stretches under three idling patterns
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_gap = 8;
                    recv_gap = 87;
                end
                1: begin
                    send_gap = 87;
                    recv_gap = 8;
                end
                default: begin
                    send_gap = 0;
                    recv_gap = 0;
                end
            endcase
            for (int sub = 0; sub < 3; sub++) begin
                write_active(plan[phase * 3 + sub]);
                run_mix(MIX_ITEMS);
            end
        end

        settle();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ filelist.f @@
src/lfupr_pkg.sv
src/lfupr_ctrl.sv
src/lfupr_datapath.sv
src/lfu_page_replacement.sv
tb/lfu_page_replacement_check.sv
tb/lfu_page_replacement_test.sv
